// ----- sv/acc_pkg.sv -----
// shared types, constants and a helper function for the alarm clock controller
package acc_pkg;

    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int CNT_W    = 6;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int IN_DW    = 8;
    localparam int OUT_DW   = 24;
    localparam int IN_UW    = 2;
    localparam int OUT_UW   = 1;

    localparam logic [HOUR_W:0] HOURS_PER_DAY = 6'd24;
    localparam logic [MIN_W:0]  MINS_PER_HOUR = 7'd60;
    localparam logic [MIN_W:0]  SECS_PER_MIN  = 7'd60;

    localparam logic [HOUR_W-1:0] CLOCK_HOUR_RST   = 5'd16;
    localparam logic [HOUR_W-1:0] ALARM_HOUR_RST   = 5'd13;
    localparam logic [MIN_W-1:0]  ALARM_MINUTE_RST = 6'd30;
    localparam logic [CNT_W-1:0]  REPEAT_RST       = 6'd15;
    localparam logic [CNT_W-1:0]  REFRESH_RST      = 6'd20;

    // register index, taken from paddr[2]
    localparam logic REG_REPEAT  = 1'b0;
    localparam logic REG_REFRESH = 1'b1;

    typedef enum logic [1:0] {
        MODE_SECOND = 2'd0,
        MODE_FAST   = 2'd1,
        MODE_SCREEN = 2'd2,
        MODE_CURSOR = 2'd3
    } acc_mode_t;

    localparam logic [1:0] SCR_TIME  = 2'd0;
    localparam logic [1:0] SCR_ALARM = 2'd1;
    localparam logic [1:0] SCR_CLOCK = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] repeat_period;
        logic [CNT_W-1:0] refresh_period;
    } acc_cfg_t;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
    } acc_hm_t;

    typedef struct packed {
        logic              hide_m;
        logic              hide_h;
        logic [MIN_W-1:0]  second;
        logic [MIN_W-1:0]  minute;
        logic [HOUR_W-1:0] hour;
        logic [1:0]        scr;
    } acc_latch_t;

    typedef struct packed {
        acc_hm_t          clock;
        logic [MIN_W-1:0] clock_second;
        acc_hm_t          alarm;
        logic [1:0]       screen;
        logic             cursor_on_minute;
        logic [CNT_W-1:0] repeat_count;
        logic [CNT_W-1:0] refresh_count;
        logic             blink_phase;
        acc_latch_t       disp;
    } acc_state_t;

    // one step of the edited field, minute carries into hour, hour wraps at 24
    function automatic acc_hm_t acc_bump(acc_hm_t t, logic on_minute);
        acc_hm_t         r;
        logic [MIN_W:0]  m_inc;
        logic [HOUR_W:0] h_inc;
        r = t;
        m_inc = {1'b0, t.minute} + 7'd1;
        if (on_minute)
        begin
            if (m_inc >= MINS_PER_HOUR)
            begin
                r.minute = '0;
                h_inc = {1'b0, t.hour} + 6'd1;
            end
            else
            begin
                r.minute = m_inc[MIN_W-1:0];
                h_inc = {1'b0, t.hour};
            end
        end
        else
        begin
            h_inc = {1'b0, t.hour} + 6'd1;
        end
        if (h_inc >= HOURS_PER_DAY)
            r.hour = '0;
        else
            r.hour = h_inc[HOUR_W-1:0];
        return r;
    endfunction

endpackage

// ----- sv/alarm_clock_controller_core.sv -----
// alarm clock controller: event register, single-pass state update, result register
// an accepted beat waits in the event register until the result register is free
// throughput: one event per cycle unless the result channel stalls; the state update
// is one pass of small compares and increments between event and result register
// reset: rst_n is asynchronous, active low; clears time 16:00:00, alarm 13:30,
// counters, blink phase and display latch, and loads the default periods
module alarm_clock_controller_core
    import acc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // event channel
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_DW-1:0]  s_axis_tdata,   // [0] inc_held, [7:1] zero
    input  logic [IN_UW-1:0]  s_axis_tuser,   // [1:0] mode
    // result channel
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [0] alarm_on, [2:1] shown_screen, [7:3] shown_hour, [13:8] shown_minute,
    // [19:14] shown_second, [20] hide_hour, [21] hide_minute, [23:22] zero
    output logic [OUT_DW-1:0] m_axis_tdata,
    output logic [OUT_UW-1:0] m_axis_tuser,   // [0] refreshed
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    acc_cfg_t   cfg;
    logic       in_valid_reg;
    acc_mode_t  mode_reg;
    logic       held_reg;
    logic       out_valid_reg;
    logic [OUT_DW-1:0] out_data_reg;
    logic [OUT_UW-1:0] out_user_reg;
    acc_state_t state_reg;
    acc_state_t state_next;
    logic       refreshed_next;
    logic       alarm_on_next;
    logic       advance;
    logic       step_en;
    logic       in_beat;

    logic [MIN_W:0]   sec_inc;
    logic [MIN_W:0]   min_inc;
    logic [HOUR_W:0]  hour_inc;
    logic [CNT_W-1:0] rc_inc;
    logic [CNT_W-1:0] fc_inc;

    acc_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        refreshed_next = 1'b0;
        sec_inc  = {1'b0, state_reg.clock_second} + 7'd1;
        min_inc  = {1'b0, state_reg.clock.minute} + 7'd1;
        hour_inc = {1'b0, state_reg.clock.hour} + 6'd1;
        rc_inc   = state_reg.repeat_count + 6'd1;
        fc_inc   = state_reg.refresh_count + 6'd1;
        unique case (mode_reg)
            MODE_SECOND:
            begin
                if (sec_inc >= SECS_PER_MIN)
                begin
                    state_next.clock_second = '0;
                    if (min_inc >= MINS_PER_HOUR)
                    begin
                        state_next.clock.minute = '0;
                        if (hour_inc >= HOURS_PER_DAY)
                            state_next.clock.hour = '0;
                        else
                            state_next.clock.hour = hour_inc[HOUR_W-1:0];
                    end
                    else
                    begin
                        state_next.clock.minute = min_inc[MIN_W-1:0];
                    end
                end
                else
                begin
                    state_next.clock_second = sec_inc[MIN_W-1:0];
                end
            end
            MODE_FAST:
            begin
                if (held_reg)
                begin
                    if (rc_inc == cfg.repeat_period)
                    begin
                        state_next.repeat_count = '0;
                        if (state_reg.screen == SCR_ALARM)
                            state_next.alarm = acc_bump(state_reg.alarm,
                                                        state_reg.cursor_on_minute);
                        else if (state_reg.screen == SCR_CLOCK)
                            state_next.clock = acc_bump(state_reg.clock,
                                                        state_reg.cursor_on_minute);
                    end
                    else
                    begin
                        state_next.repeat_count = rc_inc;
                    end
                end
                else
                begin
                    state_next.repeat_count = '0;
                end
                if (fc_inc == cfg.refresh_period)
                begin
                    state_next.refresh_count = '0;
                    refreshed_next           = 1'b1;
                    // latch sees the time after any bump of this beat
                    state_next.disp.scr    = (state_reg.screen == 2'd3) ? SCR_TIME
                                                                        : state_reg.screen;
                    state_next.disp.second = state_next.clock_second;
                    state_next.disp.hide_h = 1'b0;
                    state_next.disp.hide_m = 1'b0;
                    if (state_reg.screen == SCR_ALARM || state_reg.screen == SCR_CLOCK)
                    begin
                        if (state_reg.screen == SCR_ALARM)
                        begin
                            state_next.disp.hour   = state_next.alarm.hour;
                            state_next.disp.minute = state_next.alarm.minute;
                        end
                        else
                        begin
                            state_next.disp.hour   = state_next.clock.hour;
                            state_next.disp.minute = state_next.clock.minute;
                        end
                        // blink only while the button is released
                        if (!held_reg)
                        begin
                            if (!state_reg.blink_phase)
                            begin
                                state_next.disp.hide_m = state_reg.cursor_on_minute;
                                state_next.disp.hide_h = !state_reg.cursor_on_minute;
                            end
                            state_next.blink_phase = !state_reg.blink_phase;
                        end
                    end
                    else
                    begin
                        state_next.disp.hour   = state_next.clock.hour;
                        state_next.disp.minute = state_next.clock.minute;
                    end
                end
                else
                begin
                    state_next.refresh_count = fc_inc;
                end
            end
            MODE_SCREEN:
            begin
                if (state_reg.screen >= SCR_CLOCK)
                    state_next.screen = SCR_TIME;
                else
                    state_next.screen = state_reg.screen + 2'd1;
                state_next.cursor_on_minute = 1'b0;
            end
            MODE_CURSOR:
            begin
                state_next.cursor_on_minute = !state_reg.cursor_on_minute;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
        alarm_on_next = (state_next.alarm == state_next.clock);
    end

    // control state and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.clock.hour       <= CLOCK_HOUR_RST;
            state_reg.clock.minute     <= '0;
            state_reg.clock_second     <= '0;
            state_reg.alarm.hour       <= ALARM_HOUR_RST;
            state_reg.alarm.minute     <= ALARM_MINUTE_RST;
            state_reg.screen           <= SCR_TIME;
            state_reg.cursor_on_minute <= 1'b0;
            state_reg.repeat_count     <= '0;
            state_reg.refresh_count    <= '0;
            state_reg.blink_phase      <= 1'b0;
            state_reg.disp             <= '0;
        end
        else
        begin
            if (in_beat)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (step_en)
                state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            mode_reg <= acc_mode_t'(s_axis_tuser);
            held_reg <= s_axis_tdata[0];
        end
        if (step_en)
        begin
            out_data_reg <= {2'b00,
                             state_next.disp.hide_m,
                             state_next.disp.hide_h,
                             state_next.disp.second,
                             state_next.disp.minute,
                             state_next.disp.hour,
                             state_next.disp.scr,
                             alarm_on_next};
            out_user_reg <= refreshed_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// ----- sv/acc_cfg_regs.sv -----
// apb register file holding the repeat and refresh periods
module acc_cfg_regs
    import acc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output acc_cfg_t          cfg
);

    acc_cfg_t cfg_reg;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_period  <= REPEAT_RST;
            cfg_reg.refresh_period <= REFRESH_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_REPEAT:  cfg_reg.repeat_period  <= pwdata[CNT_W-1:0];
                REG_REFRESH: cfg_reg.refresh_period <= pwdata[CNT_W-1:0];
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_REPEAT:  prdata = {{(APB_DW-CNT_W){1'b0}}, cfg_reg.repeat_period};
            REG_REFRESH: prdata = {{(APB_DW-CNT_W){1'b0}}, cfg_reg.refresh_period};
            default:     prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/acc_checker.sv -----
// port-level checks for the alarm clock controller, bound to the top level
module acc_checker
    import acc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_DW-1:0] m_axis_tdata,
    input logic [OUT_UW-1:0] m_axis_tuser,
    input logic              pready
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // latched digits stay in range
    a_digits: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            m_axis_tdata[2:1] != 2'd3 &&
            {1'b0, m_axis_tdata[7:3]} < HOURS_PER_DAY &&
            {1'b0, m_axis_tdata[13:8]} < MINS_PER_HOUR &&
            {1'b0, m_axis_tdata[19:14]} < SECS_PER_MIN)
        else $error("shown digits out of range");

    // blanking only on an edit screen, and never both fields
    a_blank: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[20] || m_axis_tdata[21]) |->
            !(m_axis_tdata[20] && m_axis_tdata[21]) && m_axis_tdata[2:1] != SCR_TIME)
        else $error("bad blanking flags");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind alarm_clock_controller_core acc_checker u_acc_checker (.*);
